>>> rtl/svre_pkg.sv
package svre_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int PHASE_BITS      = 32;
   localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
   localparam int MUL_A_BITS      = 32;
   localparam int MUL_B_BITS      = 20;
   localparam int MUL_P_BITS      = MUL_A_BITS + MUL_B_BITS;
   localparam int FREQ_BITS       = 30;
   localparam int ENV_BITS        = 17;
   localparam int SAMPLE_BITS     = 15;

   localparam logic [35:0] PHASE_SCALE_RESET = 36'd6382652533;
   localparam logic [16:0] RAMP_STEP_RESET   = 17'd149;
   localparam logic [16:0] ENV_ONE           = 17'd65536;
   localparam logic [14:0] GAIN_Q16          = 15'd19661;

   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

   localparam logic [1:0] DIR_HOLD = 2'd0;
   localparam logic [1:0] DIR_RISE = 2'd1;
   localparam logic [1:0] DIR_FALL = 2'd2;

   localparam logic CSR_PHASE_SCALE = 1'b0;
   localparam logic CSR_RAMP_STEP   = 1'b1;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_DIV [1:9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};
   localparam longint unsigned TOP_OCTAVE_Q16 [0:11] = '{
      548668578, 581294109, 615859655, 652480576,
      691279090, 732384684, 775934544, 822074013,
      870957077, 922746880, 977616265, 1035748353};

   typedef logic [SAMPLE_BITS-1:0] qtab_type [0:QUARTER];
   typedef logic [FREQ_BITS-1:0] freq_tab_type [0:127];

   function automatic logic [SAMPLE_BITS-1:0] quarter_sine(int q);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint unsigned v;
      x = (PI_HALF_Q30 * longint'(q) + longint'(QUARTER / 2)) / QUARTER;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 9; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) begin
         v = 32767;
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int i = 0; i <= QUARTER; i++) begin
         t[i] = quarter_sine(i);
      end
      return t;
   endfunction

   function automatic freq_tab_type build_freq_tab();
      freq_tab_type t;
      longint unsigned f;
      for (int n = 0; n < 128; n++) begin
         f = TOP_OCTAVE_Q16[n % 12] >> (10 - n / 12);
         t[n] = f[FREQ_BITS-1:0];
      end
      return t;
   endfunction

   localparam freq_tab_type FREQ_TAB = build_freq_tab();

endpackage

>>> rtl/svre_mul.sv
module svre_mul
   import svre_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic [MUL_A_BITS-1:0] a,
   input  logic [MUL_B_BITS-1:0] b,
   output logic [MUL_P_BITS-1:0] prod
);

   logic [MUL_P_BITS-1:0] prod_ff;
   logic [MUL_P_BITS-1:0] prod_in;

   assign prod_in = MUL_P_BITS'(a) * MUL_P_BITS'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> rtl/svre_sine_rom.sv
module svre_sine_rom
   import svre_pkg::*;
(
   input  logic                       clock,
   input  logic [SINE_TABLE_BITS-1:0] idx,
   output logic [SAMPLE_BITS-1:0]     mag,
   output logic                       neg
);

   localparam qtab_type QTAB = build_qtab();
   localparam logic [SINE_TABLE_BITS-2:0] QUARTER_ADDR = (SINE_TABLE_BITS-1)'(QUARTER);

   logic [1:0]                 quad;
   logic [SINE_TABLE_BITS-2:0] addr;
   logic [SAMPLE_BITS-1:0]     mag_ff;
   logic                       neg_ff;

   assign quad = idx[SINE_TABLE_BITS-1 -: 2];
   assign addr = quad[0] ? QUARTER_ADDR - {1'b0, idx[SINE_TABLE_BITS-3:0]}
                         : {1'b0, idx[SINE_TABLE_BITS-3:0]};

   always_ff @(posedge clock) begin
      mag_ff <= QTAB[addr];
      neg_ff <= quad[1];
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

>>> rtl/sine_voice_with_ramp_envelope_unit.sv
// Monophonic sine voice with a linear attack/release envelope.
// req channel: tuser carries the command (tick, note on, note off),
// tdata the MIDI note. A tick word yields exactly one rsp word, a signed
// 15-bit sample; note on and note off yield none.
// csr channel: index 0 writes phase_scale, index 1 writes ramp_step. It is
// always ready; write it only while the voice is idle.
// A tick passes S_TICK_M1, S_TICK_M2 and S_TICK_FN, a silent one S_TICK_OUT,
// and raises rsp_tvalid as it leaves the last state once the output register
// is free; req_tready returns in that same cycle. A note on passes S_NOTE_LO,
// S_NOTE_HI and S_NOTE_FN. One shared 32x20 multiplier carries every product
// in turn, and req_tready stays low while it works. Note off stays in S_IDLE.
// A finished sample waits in the output register; the next word is accepted
// meanwhile, and a later sample is held back inside the unit, with req_tready
// low, until rsp_tready takes the earlier one.
// Reset (synchronous, active high) silences the voice, zeroes phase,
// increment and envelope, and restores the register defaults.
module sine_voice_with_ramp_envelope_unit
   import svre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] note, [7] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [14:0] sample, [15] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [35:0] csr_data
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_NOTE_LO = 3'd1;
   localparam logic [2:0] S_NOTE_HI = 3'd2;
   localparam logic [2:0] S_NOTE_FN = 3'd3;
   localparam logic [2:0] S_TICK_M1 = 3'd4;
   localparam logic [2:0] S_TICK_M2 = 3'd5;
   localparam logic [2:0] S_TICK_FN = 3'd6;
   localparam logic [2:0] S_TICK_OUT = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [35:0]           phase_scale_ff;
   logic [16:0]           ramp_step_ff;
   logic [PHASE_BITS-1:0] phase_acc_ff, phase_acc_in;
   logic [PHASE_BITS-1:0] phase_step_ff, phase_step_in;
   logic [ENV_BITS-1:0]   env_ff, env_in;
   logic [1:0]            dir_ff, dir_in;
   logic                  active_ff, active_in;
   logic [FREQ_BITS-1:0]  freq_ff, freq_in;
   logic [MUL_P_BITS-1:0] lo_prod_ff, lo_prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;

   logic                  accept;
   logic [1:0]            cmd;
   logic [6:0]            note;
   logic signed [18:0]    lvl;
   logic                  mul_en;
   logic [MUL_A_BITS-1:0] mul_a;
   logic [MUL_B_BITS-1:0] mul_b;
   logic [MUL_P_BITS-1:0] mul_p;
   logic [SAMPLE_BITS-1:0] rom_mag;
   logic                  rom_neg;
   logic [MUL_P_BITS:0]   inc_sum;
   logic [MUL_P_BITS:0]   rnd_sum;
   logic [SAMPLE_BITS-1:0] mag_out;
   logic                  out_free;

   assign cmd        = req_tuser;
   assign note       = req_tdata[6:0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   svre_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_p)
   );

   svre_sine_rom u_rom (
      .clock (clock),
      .idx   (phase_acc_ff[PHASE_BITS-1 -: SINE_TABLE_BITS]),
      .mag   (rom_mag),
      .neg   (rom_neg)
   );

   always_comb begin
      unique case (dir_ff)
         DIR_RISE: lvl = $signed({2'b00, env_ff}) + $signed({2'b00, ramp_step_ff});
         DIR_FALL: lvl = $signed({2'b00, env_ff}) - $signed({2'b00, ramp_step_ff});
         default:  lvl = $signed({2'b00, env_ff});
      endcase
   end

   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         S_NOTE_LO: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_BITS'(freq_ff);
            mul_b  = MUL_B_BITS'(phase_scale_ff[15:0]);
         end
         S_NOTE_HI: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_BITS'(freq_ff);
            mul_b  = phase_scale_ff[35:16];
         end
         S_TICK_M1: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_BITS'(rom_mag);
            mul_b  = MUL_B_BITS'(env_ff);
         end
         S_TICK_M2: begin
            mul_en = 1'b1;
            mul_a  = mul_p[MUL_A_BITS-1:0];
            mul_b  = MUL_B_BITS'(GAIN_Q16);
         end
         default: begin
         end
      endcase
   end

   assign inc_sum = {1'b0, mul_p} + (MUL_P_BITS+1)'(lo_prod_ff >> 16);
   assign rnd_sum = {1'b0, mul_p} + (MUL_P_BITS+1)'(64'd1 << 31);
   assign mag_out = rnd_sum[32 +: SAMPLE_BITS];

   always_comb begin
      state_in      = state_ff;
      phase_acc_in  = phase_acc_ff;
      phase_step_in = phase_step_ff;
      env_in        = env_ff;
      dir_in        = dir_ff;
      active_in     = active_ff;
      freq_in       = freq_ff;
      lo_prod_in    = lo_prod_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_NOTE_ON: begin
                     freq_in   = FREQ_TAB[note];
                     active_in = 1'b1;
                     dir_in    = DIR_RISE;
                     state_in  = S_NOTE_LO;
                  end
                  CMD_NOTE_OFF: begin
                     dir_in = DIR_FALL;
                  end
                  CMD_TICK: begin
                     if (!active_ff && env_ff == '0) begin
                        state_in = S_TICK_OUT;
                     end else if (lvl < 0) begin
                        env_in    = '0;
                        dir_in    = DIR_HOLD;
                        active_in = 1'b0;
                        state_in  = S_TICK_OUT;
                     end else begin
                        if (lvl > $signed({2'b00, ENV_ONE})) begin
                           env_in = ENV_ONE;
                           dir_in = DIR_HOLD;
                        end else begin
                           env_in = lvl[ENV_BITS-1:0];
                        end
                        state_in = S_TICK_M1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_NOTE_LO: state_in = S_NOTE_HI;
         S_NOTE_HI: begin
            lo_prod_in = mul_p;
            state_in   = S_NOTE_FN;
         end
         S_NOTE_FN: begin
            phase_step_in = inc_sum[47 -: PHASE_BITS];
            state_in      = S_IDLE;
         end
         S_TICK_M1: state_in = S_TICK_M2;
         S_TICK_M2: state_in = S_TICK_FN;
         S_TICK_FN: begin
            if (out_free) begin
               sample_in    = rom_neg ? SAMPLE_BITS'(0) - mag_out : mag_out;
               phase_acc_in = phase_acc_ff + phase_step_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TICK_OUT: begin
            if (out_free) begin
               sample_in    = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         phase_scale_ff <= PHASE_SCALE_RESET;
         ramp_step_ff   <= RAMP_STEP_RESET;
         phase_acc_ff   <= '0;
         phase_step_ff  <= '0;
         env_ff         <= '0;
         dir_ff         <= DIR_HOLD;
         active_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_acc_ff  <= phase_acc_in;
         phase_step_ff <= phase_step_in;
         env_ff        <= env_in;
         dir_ff        <= dir_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_PHASE_SCALE: phase_scale_ff <= csr_data;
               CSR_RAMP_STEP:   ramp_step_ff   <= csr_data[16:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      freq_ff    <= freq_in;
      lo_prod_ff <= lo_prod_in;
      sample_ff  <= sample_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, sample_ff};

endmodule

>>> test/sine_voice_with_ramp_envelope_unit_tb.sv
`timescale 1ns / 100ps

module sine_voice_with_ramp_envelope_unit_tb;
   import svre_pkg::*;

   localparam logic [1:0]  CMD_UNUSED      = 2'd3;
   localparam logic [35:0] PHASE_SCALE_MAX = 36'd35184372088;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 40;
   localparam longint unsigned PI_HALF = 64'd1686629713;
   localparam longint unsigned GAIN    = 64'd19661;
   localparam longint unsigned NOTE_Q16 [0:11] = '{
      548668578, 581294109, 615859655, 652480576,
      691279090, 732384684, 775934544, 822074013,
      870957077, 922746880, 977616265, 1035748353};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic [1:0]  req_tuser  = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [35:0] csr_data   = 36'd0;

   logic [35:0] scale_reg = PHASE_SCALE_RESET;
   logic [16:0] step_reg  = RAMP_STEP_RESET;
   logic [31:0] phase     = 32'd0;
   logic [31:0] phase_inc = 32'd0;
   logic [16:0] env       = 17'd0;
   logic [1:0]  env_dir   = DIR_HOLD;
   bit          playing   = 1'b0;
   int          sine_rom [0:1023];

   logic [14:0] expected_samples [$];
   logic [14:0] sample_want;
   int fail_count   = 0;
   int report_count = 0;
   int words_sent   = 0;
   int burst_left   = 0;
   int idle_cycles  = 0;
   int ready_mode   = 0;
   int ready_left   = 0;

   sine_voice_with_ramp_envelope_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int unsigned taylor_sine_q15(input int unsigned q);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint sum;
      int k;
      x = (PI_HALF * q + 64'd128) / 64'd256;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (k = 1; k <= 9; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[31:0];
   endfunction

   function automatic logic [6:0] any_note();
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic advance_voice(input logic [1:0] cmd, input logic [6:0] note);
      longint unsigned freq;
      longint unsigned incr;
      longint unsigned mag;
      longint unsigned prod;
      longint lvl;
      int s;
      bit silenced;
      logic [14:0] out;
      case (cmd)
         CMD_NOTE_ON: begin
            freq = NOTE_Q16[note % 12] >> (10 - note / 12);
            incr = (freq * longint'(scale_reg >> 16)
                    + ((freq * longint'(scale_reg[15:0])) >> 16)) >> 16;
            phase_inc = incr[31:0];
            playing = 1'b1;
            env_dir = DIR_RISE;
         end
         CMD_NOTE_OFF: begin
            env_dir = DIR_FALL;
         end
         CMD_TICK: begin
            silenced = 1'b0;
            if (!playing && env == 17'd0) begin
               silenced = 1'b1;
            end else begin
               lvl = longint'(env);
               if (env_dir == DIR_RISE) begin
                  lvl = lvl + longint'(step_reg);
               end else if (env_dir == DIR_FALL) begin
                  lvl = lvl - longint'(step_reg);
               end
               if (lvl > 65536) begin
                  env = ENV_ONE;
                  env_dir = DIR_HOLD;
               end else if (lvl < 0) begin
                  env = 17'd0;
                  env_dir = DIR_HOLD;
                  playing = 1'b0;
                  silenced = 1'b1;
               end else begin
                  env = lvl[16:0];
               end
            end
            if (silenced) begin
               expected_samples.push_back(15'd0);
            end else begin
               s = sine_rom[phase[31:22]];
               mag = (s < 0) ? longint'(-s) : longint'(s);
               prod = (mag * longint'(env) * GAIN + 64'h8000_0000) >> 32;
               out = (s < 0) ? (15'd0 - prod[14:0]) : prod[14:0];
               phase = phase + phase_inc;
               expected_samples.push_back(out);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_word(input logic [1:0] cmd, input logic [6:0] note);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {1'b0, note};
      do @(posedge clock); while (!req_tready);
      advance_voice(cmd, note);
      if (cmd != CMD_UNUSED) begin
         words_sent++;
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [35:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_PHASE_SCALE) begin
         scale_reg = data;
      end else begin
         step_reg = data[16:0];
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // silent voice, slow attack, release to exactly zero and then below
   task automatic test_idle_and_release();
      send_word(CMD_TICK, 7'd0);
      send_word(CMD_UNUSED, 7'd127);
      send_word(CMD_NOTE_OFF, 7'd0);
      send_word(CMD_TICK, 7'd127);
      send_word(CMD_NOTE_ON, 7'd69);
      repeat (3) send_word(CMD_TICK, 7'd0);
      send_word(CMD_NOTE_OFF, 7'd0);
      repeat (5) send_word(CMD_TICK, 7'd0);
   endtask

   // full-scale ramp: clamp at one, retrigger without phase reset
   task automatic test_clamp_and_retrigger();
      settle();
      write_csr(CSR_RAMP_STEP, 36'd65536);
      write_csr(CSR_PHASE_SCALE, PHASE_SCALE_MAX);
      send_word(CMD_NOTE_ON, 7'd127);
      repeat (3) send_word(CMD_TICK, 7'd0);
      send_word(CMD_NOTE_ON, 7'd0);
      send_word(CMD_TICK, 7'd0);
      send_word(CMD_NOTE_OFF, 7'd0);
      repeat (3) send_word(CMD_TICK, 7'd0);
   endtask

   // oversized increment wraps; a zero ramp keeps the envelope flat
   task automatic test_phase_wrap_and_flat_ramp();
      settle();
      write_csr(CSR_PHASE_SCALE, 36'hF_FFFF_FFFF);
      write_csr(CSR_RAMP_STEP, 36'hF_FFFE_0000);
      send_word(CMD_NOTE_ON, 7'd127);
      repeat (2) send_word(CMD_TICK, 7'd0);
      settle();
      write_csr(CSR_RAMP_STEP, 36'h0_0001_FFFF);
      repeat (2) send_word(CMD_TICK, 7'd0);
      send_word(CMD_NOTE_OFF, 7'd0);
      send_word(CMD_TICK, 7'd0);
   endtask

   task automatic test_random_voice(input logic [35:0] scale, input logic [35:0] step_word,
                                    input int count);
      int start;
      int n;
      logic [1:0] cmd_pick;
      settle();
      write_csr(CSR_PHASE_SCALE, scale);
      write_csr(CSR_RAMP_STEP, step_word);
      start = words_sent;
      while (words_sent - start < count) begin
         if ($urandom_range(0, 4) == 0) begin
            cmd_pick = 2'($urandom_range(0, 3));
            send_word(cmd_pick, any_note());
         end else begin
            send_word(CMD_NOTE_ON, any_note());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 40);
            repeat (n) send_word(CMD_TICK, any_note());
            if ($urandom_range(0, 5) != 0) begin
               send_word(CMD_NOTE_OFF, any_note());
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 40);
            repeat (n) send_word(CMD_TICK, any_note());
         end
      end
   endtask

   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         ready_left = $urandom_range(32, 256);
      end
      ready_left--;
      case (ready_mode)
         0: rsp_tready = 1'b1;
         1: rsp_tready = 1'($urandom_range(0, 1));
         default: rsp_tready = ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
               report_count++;
               $display("%0t: sample mismatch, expected no word, got %0d (%h)",
                        $time, $signed(rsp_tdata[14:0]), rsp_tdata);
            end
         end else begin
            sample_want = expected_samples.pop_front();
            if (rsp_tdata !== {1'b0, sample_want}) begin
               fail_count++;
               if (report_count < MAX_REPORTS) begin
                  report_count++;
                  $display("%0t: sample mismatch, expected %0d (%h), got %0d (%h)",
                           $time, $signed(sample_want), {1'b0, sample_want},
                           $signed(rsp_tdata[14:0]), rsp_tdata);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int i;
      int unsigned quad;
      int unsigned r;
      int unsigned v;
      logic [35:0] scale_pick;
      logic [35:0] step_pick;
      for (i = 0; i < 1024; i++) begin
         quad = i >> 8;
         r = i & 255;
         v = taylor_sine_q15(quad[0] ? 256 - r : r);
         sine_rom[i] = quad[1] ? -int'(v) : int'(v);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_and_release();
      test_clamp_and_retrigger();
      test_phase_wrap_and_flat_ramp();
      test_random_voice(PHASE_SCALE_RESET, {19'd0, RAMP_STEP_RESET}, 230);
      test_random_voice(36'd1, 36'd1, 190);
      test_random_voice(PHASE_SCALE_MAX, 36'd65536, 230);
      for (i = 0; i < 4; i++) begin
         scale_pick = {1'b0, 3'($urandom_range(0, 7)), 32'($urandom())} + 36'd1;
         step_pick = (i == 3) ? 36'($urandom_range(300, 3000))
                              : 36'($urandom_range(2000, 65536));
         test_random_voice(scale_pick, step_pick, (i == 3) ? 240 : 230);
      end
      settle();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/svre_pkg.sv
rtl/svre_mul.sv
rtl/svre_sine_rom.sv
rtl/sine_voice_with_ramp_envelope_unit.sv
test/sine_voice_with_ramp_envelope_unit_tb.sv
